[sv/sppool_pkg.sv]
// ----------------------------------------------------------------------------
// sppool_pkg
// Shared constants, register indexes and table functions for the spark pool.
// ----------------------------------------------------------------------------
package sppool_pkg;

	localparam int MAX_SPARKS_DEF = 64;
	localparam int MAX_AGE        = 40;
	localparam int POS_W          = 24;
	localparam int VEL_W          = 20;
	localparam int AGE_W          = 6;
	localparam int SPEED_W        = 9;
	localparam int CFG_IDX_W      = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 3'd4;

	localparam logic signed [15:0] CLIP_X_LOW_RST  = -16'sd64;
	localparam logic signed [15:0] CLIP_X_HIGH_RST = 16'sd6208;
	localparam logic signed [15:0] CLIP_Y_LOW_RST  = -16'sd64;
	localparam logic signed [15:0] CLIP_Y_HIGH_RST = 16'sd5952;
	localparam logic [15:0]        SEED_RST        = 16'd1;
	localparam logic [15:0]        LFSR_TAPS       = 16'hB400;

	typedef logic [8:0] quarter_t;

	function automatic logic [8:0] quarter_sine(input logic [6:0] r);
		logic [8:0] v;
		begin
			case (r)
				7'd0: v = 9'd0;     7'd1: v = 9'd6;     7'd2: v = 9'd13;    7'd3: v = 9'd19;
				7'd4: v = 9'd25;    7'd5: v = 9'd31;    7'd6: v = 9'd38;    7'd7: v = 9'd44;
				7'd8: v = 9'd50;    7'd9: v = 9'd56;    7'd10: v = 9'd62;   7'd11: v = 9'd68;
				7'd12: v = 9'd74;   7'd13: v = 9'd80;   7'd14: v = 9'd86;   7'd15: v = 9'd92;
				7'd16: v = 9'd98;   7'd17: v = 9'd104;  7'd18: v = 9'd109;  7'd19: v = 9'd115;
				7'd20: v = 9'd121;  7'd21: v = 9'd126;  7'd22: v = 9'd132;  7'd23: v = 9'd137;
				7'd24: v = 9'd142;  7'd25: v = 9'd147;  7'd26: v = 9'd152;  7'd27: v = 9'd157;
				7'd28: v = 9'd162;  7'd29: v = 9'd167;  7'd30: v = 9'd172;  7'd31: v = 9'd177;
				7'd32: v = 9'd181;  7'd33: v = 9'd185;  7'd34: v = 9'd190;  7'd35: v = 9'd194;
				7'd36: v = 9'd198;  7'd37: v = 9'd202;  7'd38: v = 9'd206;  7'd39: v = 9'd209;
				7'd40: v = 9'd213;  7'd41: v = 9'd216;  7'd42: v = 9'd220;  7'd43: v = 9'd223;
				7'd44: v = 9'd226;  7'd45: v = 9'd229;  7'd46: v = 9'd231;  7'd47: v = 9'd234;
				7'd48: v = 9'd237;  7'd49: v = 9'd239;  7'd50: v = 9'd241;  7'd51: v = 9'd243;
				7'd52: v = 9'd245;  7'd53: v = 9'd247;  7'd54: v = 9'd248;  7'd55: v = 9'd250;
				7'd56: v = 9'd251;  7'd57: v = 9'd252;  7'd58: v = 9'd253;  7'd59: v = 9'd254;
				7'd60: v = 9'd255;  7'd61: v = 9'd255;  7'd62: v = 9'd256;  7'd63: v = 9'd256;
				default: v = 9'd256;
			endcase
			return v;
		end
	endfunction

	function automatic logic signed [9:0] sine_q8(input logic [7:0] angle);
		logic [6:0] r;
		logic [8:0] v;
		begin
			r = {1'b0, angle[5:0]};
			v = angle[6] ? quarter_sine(7'd64 - r) : quarter_sine(r);
			return angle[7] ? -$signed({1'b0, v}) : $signed({1'b0, v});
		end
	endfunction

	function automatic logic [15:0] lfsr_step(input logic [15:0] s);
		begin
			return s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
		end
	endfunction

endpackage

[sv/spark_particle_pool_step_core.sv]
// ----------------------------------------------------------------------------
// spark_particle_pool_step_core
// Pool of up to 64 spark particles: burst add, per-tick motion and reporting.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken when start is high and busy is low.
//   operation 0 adds a burst at the origin, operation 1 advances one tick.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; the
//   block always takes writes, which are only legal while busy is low.
//   Results: one per active spark after a tick, on pos_x/pos_y/frame/slot,
//   marked by result_valid for one cycle, last on the final one. The
//   receiver cannot stall; results are simply presented.
// Sequence:
//   Add: quotient setup in S_DIV, then a scan over the slots; each new
//   spark passes S_ADD_SCAN, S_ADD_MX, S_ADD_MY and S_ADD_WR (one shared
//   multiplier, used for cos then sin).
//   Tick: a motion pass visits every slot, active ones through S_T_MV and
//   S_T_CK, then a report pass visits every slot again, through S_E_OUT for
//   each reported spark; the slot memories with registered reads set this
//   pace. Items are handled one at a time; busy stays high throughout.
// Reset: all slots free, clip bounds and seed at their defaults.
// ----------------------------------------------------------------------------
module spark_particle_pool_step_core #(
	parameter int MAX_SPARKS = sppool_pkg::MAX_SPARKS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               operation,
	input  logic signed [15:0]                 orig_x,
	input  logic signed [15:0]                 orig_y,
	input  logic [7:0]                         base_speed,
	input  logic [6:0]                         trail_count,
	input  logic                               explode,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sppool_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                        cfg_data,
	output logic                               result_valid,
	output logic signed [15:0]                 pos_x,
	output logic signed [15:0]                 pos_y,
	output logic [2:0]                         frame,
	output logic [5:0]                         slot,
	output logic                               last
);
	import sppool_pkg::*;

	localparam int SLOT_W = (MAX_SPARKS > 1) ? $clog2(MAX_SPARKS) : 1;
	localparam int IDX_W  = $clog2(MAX_SPARKS + 1);
	localparam logic [IDX_W-1:0] IDX_END = IDX_W'(MAX_SPARKS);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DIV      = 4'd1;
	localparam logic [3:0] S_ADD_SCAN = 4'd2;
	localparam logic [3:0] S_ADD_MX   = 4'd3;
	localparam logic [3:0] S_ADD_MY   = 4'd4;
	localparam logic [3:0] S_ADD_WR   = 4'd5;
	localparam logic [3:0] S_T_SCAN   = 4'd6;
	localparam logic [3:0] S_T_MV     = 4'd7;
	localparam logic [3:0] S_T_CK     = 4'd8;
	localparam logic [3:0] S_E_SCAN   = 4'd9;
	localparam logic [3:0] S_E_OUT    = 4'd10;

	localparam logic [1:0] MODE_FREE   = 2'd0;
	localparam logic [1:0] MODE_ACTIVE = 2'd1;
	localparam logic [1:0] MODE_DYING  = 2'd2;

	logic [3:0] state_q;
	logic [IDX_W-1:0] idx_q;
	logic [SLOT_W-1:0] addr;
	logic [1:0] mode_q [MAX_SPARKS];

	logic signed [15:0] clip_xl_q, clip_xh_q, clip_yl_q, clip_yh_q;
	logic [15:0] lfsr_q;

	logic signed [15:0] ox_q, oy_q;
	logic [7:0] base_q;
	logic [6:0] n_q, added_q;
	logic explode_q;

	logic [3:0] div_cnt_q;
	logic [7:0] div_rem_q;
	logic [8:0] step_q;
	logic [8:0] q_acc_q;
	logic [6:0] r_acc_q;

	logic [7:0] angle_q;
	logic [SPEED_W-1:0] speed_q;
	logic signed [VEL_W-1:0] prod_q;

	logic signed [POS_W-1:0] nx_q, ny_q;

	logic signed [POS_W-1:0] mem_x [MAX_SPARKS];
	logic signed [POS_W-1:0] mem_y [MAX_SPARKS];
	logic signed [VEL_W-1:0] mem_vx [MAX_SPARKS];
	logic signed [VEL_W-1:0] mem_vy [MAX_SPARKS];
	logic [AGE_W-1:0] mem_age [MAX_SPARKS];
	logic signed [POS_W-1:0] rd_x_q, rd_y_q;
	logic signed [VEL_W-1:0] rd_vx_q, rd_vy_q;
	logic [AGE_W-1:0] rd_age_q;

	logic we_pos, we_vx, we_vy, we_age;
	logic signed [POS_W-1:0] wd_x, wd_y;
	logic signed [VEL_W-1:0] wd_vy;
	logic [AGE_W-1:0] wd_age;

	logic signed [POS_W:0] sum_x, sum_y;
	logic signed [POS_W-1:0] sat_x, sat_y;
	logic signed [VEL_W:0] sum_vy;
	logic signed [VEL_W-1:0] sat_vy;
	logic [AGE_W-1:0] age_inc;
	logic clip_hit;

	logic [7:0] div_shift;
	logic div_ge;
	logic [7:0] r_sum;
	logic [15:0] lfsr_a, lfsr_b;
	logic signed [9:0] sine_sel;
	logic [7:0] sine_angle;
	logic more_active;

	assign addr      = idx_q[SLOT_W-1:0];
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign div_shift = {div_rem_q[6:0], (div_cnt_q == 4'd8)};
	assign div_ge    = (div_shift >= {1'b0, n_q});
	assign r_sum     = {1'b0, r_acc_q} + {1'b0, step_q[6:0] & 7'd0} + {1'b0, div_rem_q[6:0]};
	assign lfsr_a    = lfsr_step(lfsr_q);
	assign lfsr_b    = lfsr_step(lfsr_a);
	assign sine_angle = (state_q == S_ADD_MX) ? (angle_q + 8'd64) : angle_q;
	assign sine_sel  = sine_q8(sine_angle);

	assign sum_x = {rd_x_q[POS_W-1], rd_x_q} + (POS_W+1)'(rd_vx_q);
	assign sum_y = {rd_y_q[POS_W-1], rd_y_q} + (POS_W+1)'(rd_vy_q);
	assign sat_x = (sum_x[POS_W] != sum_x[POS_W-1]) ?
		{sum_x[POS_W], {(POS_W-1){~sum_x[POS_W]}}} : sum_x[POS_W-1:0];
	assign sat_y = (sum_y[POS_W] != sum_y[POS_W-1]) ?
		{sum_y[POS_W], {(POS_W-1){~sum_y[POS_W]}}} : sum_y[POS_W-1:0];
	assign sum_vy = {rd_vy_q[VEL_W-1], rd_vy_q} + (VEL_W+1)'(256);
	assign sat_vy = (sum_vy[VEL_W] != sum_vy[VEL_W-1]) ?
		{sum_vy[VEL_W], {(VEL_W-1){~sum_vy[VEL_W]}}} : sum_vy[VEL_W-1:0];
	assign age_inc = rd_age_q + AGE_W'(1);

	assign clip_hit = (nx_q <= $signed({clip_xl_q, 8'h00})) ||
		(nx_q >= $signed({clip_xh_q, 8'h00})) ||
		(ny_q <= $signed({clip_yl_q, 8'h00})) ||
		(ny_q >= $signed({clip_yh_q, 8'h00}));

	always_comb begin
		more_active = 1'b0;
		for (int j = 0; j < MAX_SPARKS; j++) begin
			if ((mode_q[j] == MODE_ACTIVE) && (IDX_W'(j) > idx_q))
				more_active = 1'b1;
		end
	end

	always_comb begin
		we_pos = 1'b0;
		we_vx  = 1'b0;
		we_vy  = 1'b0;
		we_age = 1'b0;
		wd_x   = sat_x;
		wd_y   = sat_y;
		wd_vy  = sat_vy;
		wd_age = age_inc;
		unique case (state_q)
			S_ADD_MY: begin
				we_vx = 1'b1;
			end
			S_ADD_WR: begin
				we_pos = 1'b1;
				we_vy  = 1'b1;
				we_age = 1'b1;
				wd_x   = {ox_q, 8'h00};
				wd_y   = {oy_q, 8'h00};
				wd_vy  = prod_q;
				wd_age = '0;
			end
			S_T_MV: begin
				we_pos = 1'b1;
			end
			S_T_CK: begin
				we_vy  = !clip_hit;
				we_age = !clip_hit;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_pos) begin
			mem_x[addr] <= wd_x;
			mem_y[addr] <= wd_y;
		end
		if (we_vx)
			mem_vx[addr] <= prod_q;
		if (we_vy)
			mem_vy[addr] <= wd_vy;
		if (we_age)
			mem_age[addr] <= wd_age;
		rd_x_q   <= mem_x[addr];
		rd_y_q   <= mem_y[addr];
		rd_vx_q  <= mem_vx[addr];
		rd_vy_q  <= mem_vy[addr];
		rd_age_q <= mem_age[addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			ox_q      <= orig_x;
			oy_q      <= orig_y;
			base_q    <= base_speed;
			n_q       <= trail_count;
			explode_q <= explode;
		end
		unique case (state_q)
			S_ADD_SCAN: begin
				if (explode_q) begin
					angle_q <= q_acc_q[7:0];
					speed_q <= SPEED_W'(base_q);
				end else begin
					angle_q <= lfsr_a[7:0];
					speed_q <= SPEED_W'(base_q) + SPEED_W'(lfsr_b[4:0]);
				end
			end
			S_ADD_MX, S_ADD_MY: begin
				prod_q <= VEL_W'($signed({1'b0, speed_q})) * VEL_W'(sine_sel);
			end
			S_T_MV: begin
				nx_q <= sat_x;
				ny_q <= sat_y;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			added_q      <= '0;
			div_cnt_q    <= '0;
			div_rem_q    <= '0;
			step_q       <= '0;
			q_acc_q      <= '0;
			r_acc_q      <= '0;
			lfsr_q       <= SEED_RST;
			clip_xl_q    <= CLIP_X_LOW_RST;
			clip_xh_q    <= CLIP_X_HIGH_RST;
			clip_yl_q    <= CLIP_Y_LOW_RST;
			clip_yh_q    <= CLIP_Y_HIGH_RST;
			result_valid <= 1'b0;
			pos_x        <= '0;
			pos_y        <= '0;
			frame        <= '0;
			slot         <= '0;
			last         <= 1'b0;
			for (int j = 0; j < MAX_SPARKS; j++)
				mode_q[j] <= MODE_FREE;
		end else begin
			result_valid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_CLIP_X_LOW:  clip_xl_q <= cfg_data;
					CFG_CLIP_X_HIGH: clip_xh_q <= cfg_data;
					CFG_CLIP_Y_LOW:  clip_yl_q <= cfg_data;
					CFG_CLIP_Y_HIGH: clip_yh_q <= cfg_data;
					CFG_RANDOM_SEED: lfsr_q <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q     <= '0;
						added_q   <= '0;
						div_cnt_q <= 4'd8;
						div_rem_q <= '0;
						step_q    <= '0;
						state_q   <= operation ? S_T_SCAN : S_DIV;
					end
				end
				S_DIV: begin
					if (n_q == 7'd0) begin
						state_q <= S_IDLE;
					end else begin
						div_rem_q <= div_ge ? (div_shift - {1'b0, n_q}) : div_shift;
						step_q    <= {step_q[7:0], div_ge};
						div_cnt_q <= div_cnt_q - 4'd1;
						if (div_cnt_q == 4'd0) begin
							q_acc_q <= '0;
							r_acc_q <= '0;
							state_q <= S_ADD_SCAN;
						end
					end
				end
				S_ADD_SCAN: begin
					if (added_q == n_q || idx_q == IDX_END) begin
						state_q <= S_IDLE;
					end else if (mode_q[addr] == MODE_FREE) begin
						if (explode_q) begin
							if (r_sum >= {1'b0, n_q}) begin
								r_acc_q <= 7'(r_sum - {1'b0, n_q});
								q_acc_q <= q_acc_q + step_q + 9'd1;
							end else begin
								r_acc_q <= r_sum[6:0];
								q_acc_q <= q_acc_q + step_q;
							end
						end else begin
							lfsr_q <= lfsr_b;
						end
						state_q <= S_ADD_MX;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_ADD_MX: state_q <= S_ADD_MY;
				S_ADD_MY: state_q <= S_ADD_WR;
				S_ADD_WR: begin
					mode_q[addr] <= MODE_ACTIVE;
					added_q      <= added_q + 7'd1;
					idx_q        <= idx_q + IDX_W'(1);
					state_q      <= S_ADD_SCAN;
				end
				S_T_SCAN: begin
					if (idx_q == IDX_END) begin
						idx_q   <= '0;
						state_q <= S_E_SCAN;
					end else if (mode_q[addr] != MODE_ACTIVE) begin
						mode_q[addr] <= MODE_FREE;
						idx_q        <= idx_q + IDX_W'(1);
					end else begin
						state_q <= S_T_MV;
					end
				end
				S_T_MV: state_q <= S_T_CK;
				S_T_CK: begin
					if (clip_hit || age_inc > AGE_W'(MAX_AGE))
						mode_q[addr] <= MODE_DYING;
					idx_q   <= idx_q + IDX_W'(1);
					state_q <= S_T_SCAN;
				end
				S_E_SCAN: begin
					if (idx_q == IDX_END)
						state_q <= S_IDLE;
					else if (mode_q[addr] == MODE_ACTIVE)
						state_q <= S_E_OUT;
					else
						idx_q <= idx_q + IDX_W'(1);
				end
				S_E_OUT: begin
					result_valid <= 1'b1;
					pos_x        <= rd_x_q[POS_W-1:8];
					pos_y        <= rd_y_q[POS_W-1:8];
					frame        <= rd_age_q[2:0];
					slot         <= 6'(addr);
					last         <= !more_active;
					idx_q        <= idx_q + IDX_W'(1);
					state_q      <= S_E_SCAN;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[sv/sppool_checker.sv]
// ----------------------------------------------------------------------------
// sppool_checker
// Port-level checks for the spark pool core, bound to the top level.
// ----------------------------------------------------------------------------
module sppool_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_valid,
	input logic last
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_result_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without work in progress");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |=> !result_valid)
		else $error("result follows the last item of a tick");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !$past(busy)) |-> !result_valid)
		else $error("result while idle");

endmodule

bind spark_particle_pool_step_core sppool_checker u_sppool_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.result_valid(result_valid),
	.last(last)
);

[tb/spark_pool_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spark_pool_checker
// Watches the command, config and result channels of the spark pool, keeps
// its own copy of the pool state, predicts the sparks that every tick
// reports and compares each result field by field in order.
// ----------------------------------------------------------------------------
module spark_pool_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic                             operation,
	input  logic signed [15:0]               orig_x,
	input  logic signed [15:0]               orig_y,
	input  logic [7:0]                       base_speed,
	input  logic [6:0]                       trail_count,
	input  logic                             explode,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [sppool_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                      cfg_data,
	input  logic                             result_valid,
	input  logic signed [15:0]               pos_x,
	input  logic signed [15:0]               pos_y,
	input  logic [2:0]                       frame,
	input  logic [5:0]                       slot,
	input  logic                             last,
	output int                               fail_count,
	output int                               pending
);
	import sppool_pkg::*;

	localparam int POOL     = 64;
	localparam int POS_HI   = 8388607;
	localparam int POS_LO   = -8388608;
	localparam int VEL_HI   = 524287;
	localparam int VEL_LO   = -524288;
	localparam int GRAVITY  = 256;
	localparam int SPARK_FREE   = 0;
	localparam int SPARK_ACTIVE = 1;
	localparam int SPARK_DYING  = 2;

	localparam int SINE_QTR [0:64] = '{
		0, 6, 13, 19, 25, 31, 38, 44, 50, 56, 62, 68, 74, 80, 86, 92,
		98, 104, 109, 115, 121, 126, 132, 137, 142, 147, 152, 157, 162, 167, 172, 177,
		181, 185, 190, 194, 198, 202, 206, 209, 213, 216, 220, 223, 226, 229, 231, 234,
		237, 239, 241, 243, 245, 247, 248, 250, 251, 252, 253, 254, 255, 255, 256, 256,
		256};

	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic [2:0]         frm;
		logic [5:0]         idx;
		logic               fin;
	} spark_report_t;

	spark_report_t spark_reports [$];

	int             clip_xl, clip_xh, clip_yl, clip_yh;
	logic [15:0]    rng;
	int             mode_q [POOL];
	int             age_q  [POOL];
	int             x_q    [POOL];
	int             y_q    [POOL];
	int             vx_q   [POOL];
	int             vy_q   [POOL];

	assign pending = spark_reports.size();

	function automatic int sine_of(input int angle);
		int a;
		int v;
		a = angle & 255;
		v = ((a >> 6) & 1) ? SINE_QTR[64 - (a & 63)] : SINE_QTR[a & 63];
		return ((a >> 7) & 1) ? -v : v;
	endfunction

	function automatic int clamp(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic [15:0] advance_rng();
		rng = rng[0] ? ((rng >> 1) ^ 16'hB400) : (rng >> 1);
		return rng;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("%0t: mismatch %s got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic clear_pool();
		for (int i = 0; i < POOL; i++) begin
			mode_q[i] = SPARK_FREE;
			age_q[i] = 0;
			x_q[i] = 0;
			y_q[i] = 0;
			vx_q[i] = 0;
			vy_q[i] = 0;
		end
	endtask

	task automatic add_sparks();
		int ox, oy, n, added, angle, speed;
		ox = int'(orig_x) * 256;
		oy = int'(orig_y) * 256;
		n = int'(trail_count);
		added = 0;
		if (n == 0)
			return;
		for (int i = 0; i < POOL && added < n; i++) begin
			if (mode_q[i] != SPARK_FREE)
				continue;
			mode_q[i] = SPARK_ACTIVE;
			age_q[i] = 0;
			x_q[i] = ox;
			y_q[i] = oy;
			if (explode) begin
				angle = (added * 256) / n;
				speed = int'(base_speed);
			end else begin
				angle = int'(advance_rng()) & 255;
				speed = int'(base_speed) + (int'(advance_rng()) & 31);
			end
			vx_q[i] = speed * sine_of(angle + 64);
			vy_q[i] = speed * sine_of(angle);
			added++;
		end
	endtask

	task automatic tick_sparks();
		spark_report_t r;
		int count;
		count = 0;
		for (int i = 0; i < POOL; i++) begin
			if (mode_q[i] != SPARK_ACTIVE) begin
				mode_q[i] = SPARK_FREE;
				continue;
			end
			x_q[i] = clamp(x_q[i] + vx_q[i], POS_LO, POS_HI);
			y_q[i] = clamp(y_q[i] + vy_q[i], POS_LO, POS_HI);
			if (x_q[i] <= clip_xl * 256 || x_q[i] >= clip_xh * 256 ||
					y_q[i] <= clip_yl * 256 || y_q[i] >= clip_yh * 256) begin
				mode_q[i] = SPARK_DYING;
				continue;
			end
			vy_q[i] = clamp(vy_q[i] + GRAVITY, VEL_LO, VEL_HI);
			age_q[i] = (age_q[i] + 1) & 63;
			if (age_q[i] > MAX_AGE)
				mode_q[i] = SPARK_DYING;
		end
		for (int i = 0; i < POOL; i++) begin
			if (mode_q[i] != SPARK_ACTIVE)
				continue;
			r.px = 16'(x_q[i] >>> 8);
			r.py = 16'(y_q[i] >>> 8);
			r.frm = 3'(age_q[i]);
			r.idx = 6'(i);
			r.fin = 1'b0;
			spark_reports.push_back(r);
			count++;
		end
		if (count > 0)
			spark_reports[spark_reports.size() - 1].fin = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		spark_report_t want;
		if (!arst_n) begin
			clip_xl = int'(CLIP_X_LOW_RST);
			clip_xh = int'(CLIP_X_HIGH_RST);
			clip_yl = int'(CLIP_Y_LOW_RST);
			clip_yh = int'(CLIP_Y_HIGH_RST);
			rng = SEED_RST;
			clear_pool();
			spark_reports.delete();
		end else begin
			if (result_valid) begin
				if (spark_reports.size() == 0) begin
					report("unexpected result, slot", int'(slot), -1);
				end else begin
					want = spark_reports.pop_front();
					if (pos_x !== want.px) report("pos_x", int'(pos_x), int'(want.px));
					if (pos_y !== want.py) report("pos_y", int'(pos_y), int'(want.py));
					if (frame !== want.frm) report("frame", int'(frame), int'(want.frm));
					if (slot !== want.idx) report("slot", int'(slot), int'(want.idx));
					if (last !== want.fin) report("last", int'(last), int'(want.fin));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CLIP_X_LOW:  clip_xl = int'($signed(cfg_data));
					CFG_CLIP_X_HIGH: clip_xh = int'($signed(cfg_data));
					CFG_CLIP_Y_LOW:  clip_yl = int'($signed(cfg_data));
					CFG_CLIP_Y_HIGH: clip_yh = int'($signed(cfg_data));
					CFG_RANDOM_SEED: rng = (cfg_data == 16'd0) ? 16'd1 : cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (operation)
					tick_sparks();
				else
					add_sparks();
			end
		end
	end

	initial fail_count = 0;

endmodule

[tb/tb_spark_particle_pool_step_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spark_particle_pool_step_core
// Drives bursts and ticks into the spark pool under several clip and seed
// settings, with random idle gaps; a checker beside the block predicts and
// compares every reported spark.
// ----------------------------------------------------------------------------
module tb_spark_particle_pool_step_core;
	import sppool_pkg::*;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;
	localparam int   SETTLE  = 600;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic                   operation;
	logic signed [15:0]     orig_x;
	logic signed [15:0]     orig_y;
	logic [7:0]             base_speed;
	logic [6:0]             trail_count;
	logic                   explode;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [15:0]            cfg_data;
	logic                   result_valid;
	logic signed [15:0]     pos_x;
	logic signed [15:0]     pos_y;
	logic [2:0]             frame;
	logic [5:0]             slot;
	logic                   last;
	int                     fail_count;
	int                     pending;
	bit                     quiet;

	spark_particle_pool_step_core DUT (.*);

	spark_pool_checker u_checker (.*);

	always #6 clk = ~clk;

	initial begin
		#20ms;
		$display("spark_particle_pool_step_core test failed");
		$finish;
	end

	task automatic idle_gap();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic send_item(input logic op, input int ox, input int oy, input int spd,
			input int cnt, input logic expl);
		start <= 1'b1;
		operation <= op;
		orig_x <= 16'(ox);
		orig_y <= 16'(oy);
		base_speed <= 8'(spd);
		trail_count <= 7'(cnt);
		explode <= expl;
		do @(negedge clk); while (busy);
		@(posedge clk);
		idle_gap();
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(value);
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_item();
		int ox, oy, spd, cnt, pick;
		if ($urandom_range(0, 9) < 7) begin
			send_item(OP_TICK, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
			return;
		end
		pick = $urandom_range(0, 9);
		ox = (pick < 8) ? $urandom_range(0, 6000) : int'($urandom);
		oy = (pick < 8) ? $urandom_range(0, 5000) : int'($urandom);
		spd = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 40) : $urandom_range(0, 255);
		pick = $urandom_range(0, 9);
		cnt = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(64, 127) : $urandom_range(1, 16);
		send_item(OP_ADD, ox, oy, spd, cnt, 1'($urandom));
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_ADD;
		orig_x = '0;
		orig_y = '0;
		base_speed = '0;
		trail_count = '0;
		explode = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CLIP_X_LOW;
		cfg_data = '0;
		quiet = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_TICK, 0, 0, 0, 0, 1'b0);
		send_item(OP_ADD, 3000, 2000, 10, 8, 1'b1);
		send_item(OP_TICK, 0, 0, 0, 0, 1'b0);
		send_item(OP_ADD, 100, 100, 0, 0, 1'b0);
		send_item(OP_ADD, 1000, 1000, 255, 5, 1'b0);
		send_item(OP_TICK, -1, -1, 255, 127, 1'b1);
		send_item(OP_ADD, 500, 4000, 3, 127, 1'b1);
		send_item(OP_ADD, 500, 500, 3, 4, 1'b0);
		send_item(OP_TICK, 0, 0, 0, 0, 1'b0);
		send_item(OP_TICK, 0, 0, 0, 0, 1'b0);
		drain();
		write_reg(CFG_CLIP_X_LOW, -32768);
		write_reg(CFG_CLIP_X_HIGH, 32767);
		write_reg(CFG_CLIP_Y_LOW, -32768);
		write_reg(CFG_CLIP_Y_HIGH, 32767);
		write_reg(CFG_RANDOM_SEED, 0);
		write_reg(CFG_RANDOM_SEED + 3'd1, 1234);
		send_item(OP_TICK, 0, 0, 0, 0, 1'b0);
		send_item(OP_ADD, 32767, -32768, 255, 64, 1'b1);
		send_item(OP_ADD, -32768, 32767, 255, 1, 1'b1);
		send_item(OP_TICK, 0, 0, 0, 0, 1'b0);
		send_item(OP_ADD, 32767, 32767, 255, 3, 1'b0);
		send_item(OP_TICK, 0, 0, 0, 0, 1'b0);
		send_item(OP_TICK, 0, 0, 0, 0, 1'b0);
		send_item(OP_ADD, -32768, -32768, 0, 1, 1'b0);
		send_item(OP_TICK, 0, 0, 0, 0, 1'b0);

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: begin
					write_reg(CFG_CLIP_X_LOW, -64);
					write_reg(CFG_CLIP_X_HIGH, 6208);
					write_reg(CFG_CLIP_Y_LOW, -64);
					write_reg(CFG_CLIP_Y_HIGH, 5952);
					write_reg(CFG_RANDOM_SEED, 65535);
				end
				1: begin
					write_reg(CFG_CLIP_X_LOW, 32767);
					write_reg(CFG_CLIP_X_HIGH, -32768);
					write_reg(CFG_RANDOM_SEED, 1);
				end
				2: begin
					write_reg(CFG_CLIP_X_LOW, -32768);
					write_reg(CFG_CLIP_X_HIGH, 32767);
					write_reg(CFG_CLIP_Y_LOW, -32768);
					write_reg(CFG_CLIP_Y_HIGH, 32767);
					write_reg(CFG_RANDOM_SEED, $urandom_range(1, 65535));
				end
				default: begin
					write_reg(CFG_CLIP_X_LOW, $urandom_range(0, 1500) - 200);
					write_reg(CFG_CLIP_X_HIGH, $urandom_range(3000, 7000));
					write_reg(CFG_CLIP_Y_LOW, $urandom_range(0, 1500) - 200);
					write_reg(CFG_CLIP_Y_HIGH, $urandom_range(3000, 7000));
					write_reg(CFG_RANDOM_SEED, $urandom);
				end
			endcase
			quiet = (ph == 5);
			for (int k = 0; k < 73; k++) begin
				if (ph == 3 && k == 30)
					drain();
				random_item();
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("spark_particle_pool_step_core test passed");
		else
			$display("spark_particle_pool_step_core test failed");
		$finish;
	end

endmodule
